/* hdl/sssf_pkg.sv */
// ----------------------------------------------------------------------------
// sssf_pkg: shared types and constants for the settled state frame sender
// command kinds, frame kinds, register map, reset values and item structs
// ----------------------------------------------------------------------------
package sssf_pkg;

  // command item kinds
  typedef enum logic [2:0] {
    KIND_TICK    = 3'd0,
    KIND_POWER   = 3'd1,
    KIND_MODE    = 3'd2,
    KIND_FAN     = 3'd3,
    KIND_SWING_V = 3'd4,
    KIND_SWING_H = 3'd5,
    KIND_DELTA   = 3'd6
  } kind_t;

  // frame kinds on the result channel
  typedef enum logic [1:0] {
    FRAME_NONE    = 2'd0,
    FRAME_CHANGE  = 2'd1,
    FRAME_REFRESH = 2'd2
  } frame_t;

  // register indexes (byte address is 4 times the index)
  typedef enum logic [1:0] {
    REG_SETTLE  = 2'd0,
    REG_REFRESH = 2'd1,
    REG_MIN_SP  = 2'd2,
    REG_MAX_SP  = 2'd3
  } reg_idx_t;

  // value limits of the settings
  localparam logic [2:0] POWER_COUNT = 3'd2;
  localparam logic [2:0] MODE_COUNT  = 3'd3;
  localparam logic [2:0] FAN_COUNT   = 3'd4;
  localparam logic [2:0] SWING_COUNT = 3'd2;

  localparam logic [15:0] SETTLE_MAX = 16'hFFFF;
  localparam logic [19:0] SEND_MAX   = 20'hFFFFF;

  // register reset values
  localparam logic [15:0] SETTLE_RST  = 16'd700;
  localparam logic [19:0] REFRESH_RST = 20'd600000;
  localparam logic [6:0]  MIN_SP_RST  = 7'd61;
  localparam logic [6:0]  MAX_SP_RST  = 7'd86;

  // state reset values
  localparam logic [1:0] MODE_RST     = 2'd2;
  localparam logic [6:0] SETPOINT_RST = 7'd72;

  typedef struct packed {
    logic [15:0] settle_ticks;
    logic [19:0] refresh_ticks;
    logic [6:0]  min_setpoint;
    logic [6:0]  max_setpoint;
  } cfg_t;

  typedef struct packed {
    logic [2:0]        kind;
    logic [1:0]        setting;
    logic signed [7:0] delta;
  } item_t;

  typedef struct packed {
    frame_t     frame_kind;
    logic       power_on;
    logic [1:0] mode_now;
    logic [6:0] setpoint_now;
    logic [1:0] fan_now;
    logic       swing_vertical;
    logic       swing_horizontal;
    logic       is_pending;
  } result_t;

endpackage

/* hdl/settled_state_frame_sender_top.sv */
// ----------------------------------------------------------------------------
// settled_state_frame_sender_top: air-conditioner command shadow and sender
// keeps the whole command state and emits change and refresh frames
// ----------------------------------------------------------------------------
// usage
//   in_*  : command and tick items; in_tuser carries the kind, in_tdata the
//           setting and the signed setpoint delta
//   out_* : one result item per input item; out_tuser is the frame kind
//           (none, settled change, periodic refresh), out_tdata the whole
//           command state after the item and the pending flag
//   cfg_* : apb-style register port, settle ticks at 0x0, refresh ticks at
//           0x4, minimum setpoint at 0x8, maximum setpoint at 0xc
// path: an accepted item goes to the input register, the state update
//   runs on it combinationally, then the result register takes the result
// throughput: one item per cycle unless out_tready stalls the result
//   register, set by the single state update pass
// reset: rst_n is synchronous; registers return to their defaults, the
//   command state to off, cool, 72 F, fan auto, vanes fixed, nothing pending
// stall: while out_tready is low the result register holds; one more item
//   waits in the input register, then in_tready drops
// ----------------------------------------------------------------------------
module settled_state_frame_sender_top import sssf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [1:0] setting, [9:2] delta, [15:10] zero
  input  logic [2:0]  in_tuser,   // [2:0] kind
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [0] power_on, [2:1] mode_now,
                                  // [9:3] setpoint_now, [11:10] fan_now,
                                  // [12] swing_vertical, [13] swing_horizontal,
                                  // [14] is_pending, [15] zero
  output logic [1:0]  out_tuser,  // [1:0] frame_kind
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  cfg_t    cfg;
  item_t   item_r;
  logic    in_valid_r;
  logic    out_valid_r;
  result_t res;
  result_t res_r;
  logic    advance;

  assign cfg_pready = 1'b1;

  sssf_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  // the held item moves on whenever the result register is free or draining
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.kind    <= in_tuser;
      item_r.setting <= in_tdata[1:0];
      item_r.delta   <= $signed(in_tdata[9:2]);
    end
  end

  sssf_state u_state (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (advance),
    .item  (item_r),
    .cfg   (cfg),
    .res   (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.frame_kind;
  assign out_tdata  = {1'b0, res_r.is_pending, res_r.swing_horizontal,
                       res_r.swing_vertical, res_r.fan_now, res_r.setpoint_now,
                       res_r.mode_now, res_r.power_on};

endmodule

/* hdl/sssf_cfg.sv */
// ----------------------------------------------------------------------------
// sssf_cfg: configuration registers
// apb-style write and read of the settle, refresh and setpoint bound registers
// ----------------------------------------------------------------------------
module sssf_cfg import sssf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output cfg_t        cfg
);

  cfg_t     cfg_r;
  logic     wr_en;
  reg_idx_t idx;

  assign idx   = reg_idx_t'(paddr[3:2]);
  assign wr_en = psel && penable && pwrite;
  assign cfg   = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.settle_ticks  <= SETTLE_RST;
      cfg_r.refresh_ticks <= REFRESH_RST;
      cfg_r.min_setpoint  <= MIN_SP_RST;
      cfg_r.max_setpoint  <= MAX_SP_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_SETTLE:  cfg_r.settle_ticks  <= pwdata[15:0];
        REG_REFRESH: cfg_r.refresh_ticks <= pwdata[19:0];
        REG_MIN_SP:  cfg_r.min_setpoint  <= pwdata[6:0];
        REG_MAX_SP:  cfg_r.max_setpoint  <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SETTLE:  prdata = {16'd0, cfg_r.settle_ticks};
      REG_REFRESH: prdata = {12'd0, cfg_r.refresh_ticks};
      REG_MIN_SP:  prdata = {25'd0, cfg_r.min_setpoint};
      REG_MAX_SP:  prdata = {25'd0, cfg_r.max_setpoint};
      default:     prdata = 32'd0;
    endcase
  end

endmodule

/* hdl/sssf_state.sv */
// ----------------------------------------------------------------------------
// sssf_state: command shadow state and tick counters
// applies one item per cycle when fire is high and presents the state after that item
// ----------------------------------------------------------------------------
module sssf_state import sssf_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    fire,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t res
);

  logic        power_r, power_nxt;
  logic [1:0]  mode_r, mode_nxt;
  logic [6:0]  setpoint_r, setpoint_nxt;
  logic [1:0]  fan_r, fan_nxt;
  logic        vane_v_r, vane_v_nxt;
  logic        vane_h_r, vane_h_nxt;
  logic        pending_r, pending_nxt;
  logic [15:0] since_change_r, since_change_nxt;
  logic [19:0] since_send_r, since_send_nxt;
  logic        ever_sent_r, ever_sent_nxt;
  frame_t      frame;

  logic [2:0]        set_ext;
  logic [15:0]       change_inc;
  logic [19:0]       send_inc;
  logic signed [8:0] want;
  logic signed [8:0] want_lo;
  logic signed [8:0] want_hi;
  logic [6:0]        clamped;

  assign set_ext    = {1'b0, item.setting};
  assign change_inc = (since_change_r != SETTLE_MAX) ? since_change_r + 16'd1 : since_change_r;
  assign send_inc   = (since_send_r != SEND_MAX) ? since_send_r + 20'd1 : since_send_r;

  // clamp to the minimum first, then to the maximum
  always_comb begin
    want    = $signed({2'b00, setpoint_r}) + 9'(item.delta);
    want_lo = (want < $signed({2'b00, cfg.min_setpoint})) ?
              $signed({2'b00, cfg.min_setpoint}) : want;
    want_hi = (want_lo > $signed({2'b00, cfg.max_setpoint})) ?
              $signed({2'b00, cfg.max_setpoint}) : want_lo;
    clamped = want_hi[6:0];
  end

  always_comb begin
    power_nxt        = power_r;
    mode_nxt         = mode_r;
    setpoint_nxt     = setpoint_r;
    fan_nxt          = fan_r;
    vane_v_nxt       = vane_v_r;
    vane_h_nxt       = vane_h_r;
    pending_nxt      = pending_r;
    since_change_nxt = since_change_r;
    since_send_nxt   = since_send_r;
    ever_sent_nxt    = ever_sent_r;
    frame            = FRAME_NONE;

    unique case (kind_t'(item.kind))
      KIND_TICK: begin
        since_change_nxt = change_inc;
        if (pending_r) begin
          if (change_inc >= cfg.settle_ticks) begin
            pending_nxt    = 1'b0;
            since_send_nxt = 20'd0;
            ever_sent_nxt  = 1'b1;
            frame          = FRAME_CHANGE;
          end
        end else if (ever_sent_r) begin
          if (send_inc >= cfg.refresh_ticks) begin
            since_send_nxt = 20'd0;
            frame          = FRAME_REFRESH;
          end else begin
            since_send_nxt = send_inc;
          end
        end
      end
      KIND_POWER: begin
        if (set_ext < POWER_COUNT && item.setting[0] != power_r) begin
          power_nxt        = item.setting[0];
          pending_nxt      = 1'b1;
          since_change_nxt = 16'd0;
        end
      end
      KIND_MODE: begin
        if (set_ext < MODE_COUNT && item.setting != mode_r) begin
          mode_nxt         = item.setting;
          pending_nxt      = 1'b1;
          since_change_nxt = 16'd0;
        end
      end
      KIND_FAN: begin
        if (set_ext < FAN_COUNT && item.setting != fan_r) begin
          fan_nxt          = item.setting;
          pending_nxt      = 1'b1;
          since_change_nxt = 16'd0;
        end
      end
      KIND_SWING_V: begin
        if (set_ext < SWING_COUNT && item.setting[0] != vane_v_r) begin
          vane_v_nxt       = item.setting[0];
          pending_nxt      = 1'b1;
          since_change_nxt = 16'd0;
        end
      end
      KIND_SWING_H: begin
        if (set_ext < SWING_COUNT && item.setting[0] != vane_h_r) begin
          vane_h_nxt       = item.setting[0];
          pending_nxt      = 1'b1;
          since_change_nxt = 16'd0;
        end
      end
      KIND_DELTA: begin
        if (clamped != setpoint_r) begin
          setpoint_nxt     = clamped;
          pending_nxt      = 1'b1;
          since_change_nxt = 16'd0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      power_r        <= 1'b0;
      mode_r         <= MODE_RST;
      setpoint_r     <= SETPOINT_RST;
      fan_r          <= 2'd0;
      vane_v_r       <= 1'b0;
      vane_h_r       <= 1'b0;
      pending_r      <= 1'b0;
      since_change_r <= 16'd0;
      since_send_r   <= 20'd0;
      ever_sent_r    <= 1'b0;
    end else if (fire) begin
      power_r        <= power_nxt;
      mode_r         <= mode_nxt;
      setpoint_r     <= setpoint_nxt;
      fan_r          <= fan_nxt;
      vane_v_r       <= vane_v_nxt;
      vane_h_r       <= vane_h_nxt;
      pending_r      <= pending_nxt;
      since_change_r <= since_change_nxt;
      since_send_r   <= since_send_nxt;
      ever_sent_r    <= ever_sent_nxt;
    end
  end

  always_comb begin
    res.frame_kind       = frame;
    res.power_on         = power_nxt;
    res.mode_now         = mode_nxt;
    res.setpoint_now     = setpoint_nxt;
    res.fan_now          = fan_nxt;
    res.swing_vertical   = vane_v_nxt;
    res.swing_horizontal = vane_h_nxt;
    res.is_pending       = pending_nxt;
  end

endmodule

/* tb/sv/settled_state_frame_sender_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// settled_state_frame_sender_top_tb: self-checking bench for the command sender
// drives command and tick items with random gaps and result stalls, keeps a
// shadow of the command state and counters, and checks every result item
// ----------------------------------------------------------------------------
module settled_state_frame_sender_top_tb;
  import sssf_pkg::*;

  // kind code the block must ignore
  localparam logic [2:0] KIND_UNUSED = 3'd7;
  // receiver hold-off length for the backpressure test
  localparam int unsigned HOLD_OFF_CYCLES = 300;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // [1:0] setting, [9:2] delta, [15:10] zero
  logic [2:0]  in_tuser;   // [2:0] kind
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // [0] power_on, [2:1] mode_now, [9:3] setpoint_now,
                           // [11:10] fan_now, [12] swing_vertical,
                           // [13] swing_horizontal, [14] is_pending, [15] zero
  logic [1:0]  out_tuser;  // [1:0] frame_kind
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  settled_state_frame_sender_top i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // shadow of the register file
  logic [15:0] lim_settle;
  logic [19:0] lim_refresh;
  logic [6:0]  lim_min_sp;
  logic [6:0]  lim_max_sp;

  // shadow of the command state and the tick counters
  logic        sh_power;
  logic [1:0]  sh_mode;
  logic [6:0]  sh_setpoint;
  logic [1:0]  sh_fan;
  logic        sh_vane_v;
  logic        sh_vane_h;
  logic        sh_pending;
  logic [15:0] quiet_ticks;
  logic [19:0] ticks_since_send;
  logic        sent_once;

  // state reports still to come out, oldest first
  result_t     reports_due[$];

  int unsigned mismatches;
  int unsigned items_sent;
  bit          steady;        // no idling on either side while set
  bit          hold_off_req;  // asks the receiver for one long hold-off

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // most gaps short, a few long, none while steady
  function automatic int unsigned idle_len();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 20);
  endfunction

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // any real change arms the settle wait
  task automatic adopt_setting(inout logic [1:0] field, input logic [1:0] value,
                               input logic [2:0] count);
    if ({1'b0, value} < count && field != value) begin
      field       = value;
      sh_pending  = 1'b1;
      quiet_ticks = '0;
    end
  endtask

  task automatic advance_shadow(input logic [2:0] kind, input logic [1:0] setting,
                                input logic signed [7:0] delta, output result_t r);
    frame_t     frame;
    int         want;
    logic [1:0] one_bit;
    frame = FRAME_NONE;
    case (kind)
      KIND_TICK: begin
        if (quiet_ticks != SETTLE_MAX) quiet_ticks = quiet_ticks + 1'b1;
        if (sh_pending) begin
          // settled: the change frame goes and restarts the refresh count
          if (quiet_ticks >= lim_settle) begin
            sh_pending       = 1'b0;
            ticks_since_send = '0;
            sent_once        = 1'b1;
            frame            = FRAME_CHANGE;
          end
        end else if (sent_once) begin
          if (ticks_since_send != SEND_MAX) ticks_since_send = ticks_since_send + 1'b1;
          if (ticks_since_send >= lim_refresh) begin
            ticks_since_send = '0;
            frame            = FRAME_REFRESH;
          end
        end
      end
      KIND_POWER: begin
        one_bit = {1'b0, sh_power};
        adopt_setting(one_bit, setting, POWER_COUNT);
        sh_power = one_bit[0];
      end
      KIND_MODE: adopt_setting(sh_mode, setting, MODE_COUNT);
      KIND_FAN:  adopt_setting(sh_fan, setting, FAN_COUNT);
      KIND_SWING_V: begin
        one_bit = {1'b0, sh_vane_v};
        adopt_setting(one_bit, setting, SWING_COUNT);
        sh_vane_v = one_bit[0];
      end
      KIND_SWING_H: begin
        one_bit = {1'b0, sh_vane_h};
        adopt_setting(one_bit, setting, SWING_COUNT);
        sh_vane_h = one_bit[0];
      end
      KIND_DELTA: begin
        // lower clamp first, so an inverted range ends at the maximum
        want = int'(sh_setpoint) + int'(delta);
        if (want < int'(lim_min_sp)) want = int'(lim_min_sp);
        if (want > int'(lim_max_sp)) want = int'(lim_max_sp);
        if (want != int'(sh_setpoint)) begin
          sh_setpoint = want[6:0];
          sh_pending  = 1'b1;
          quiet_ticks = '0;
        end
      end
      default: ;  // unused kind: nothing moves
    endcase
    r.frame_kind       = frame;
    r.power_on         = sh_power;
    r.mode_now         = sh_mode;
    r.setpoint_now     = sh_setpoint;
    r.fan_now          = sh_fan;
    r.swing_vertical   = sh_vane_v;
    r.swing_horizontal = sh_vane_h;
    r.is_pending       = sh_pending;
  endtask

  // every accepted item gets its expected state report
  always @(posedge clk) begin : predict_reports
    result_t r;
    if (rst_n && in_tvalid && in_tready) begin
      advance_shadow(in_tuser, in_tdata[1:0], in_tdata[9:2], r);
      reports_due.push_back(r);
    end
  end

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic note_mismatch(input string what, input int exp_val, input int act_val);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t mismatch %s: expected %0d, got %0d", $realtime, what, exp_val, act_val);
  endtask

  task automatic check_field(input string what, input int exp_val, input int act_val);
    if (exp_val != act_val) note_mismatch(what, exp_val, act_val);
  endtask

  always @(posedge clk) begin : check_reports
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (reports_due.size() == 0) begin
        // -1 marks that nothing was due
        note_mismatch("result with nothing due, tdata", -1, int'(out_tdata));
      end else begin
        want = reports_due.pop_front();
        check_field("frame_kind", int'(want.frame_kind), int'(out_tuser));
        check_field("power_on", int'(want.power_on), int'(out_tdata[0]));
        check_field("mode_now", int'(want.mode_now), int'(out_tdata[2:1]));
        check_field("setpoint_now", int'(want.setpoint_now), int'(out_tdata[9:3]));
        check_field("fan_now", int'(want.fan_now), int'(out_tdata[11:10]));
        check_field("swing_vertical", int'(want.swing_vertical), int'(out_tdata[12]));
        check_field("swing_horizontal", int'(want.swing_horizontal),
                    int'(out_tdata[13]));
        check_field("is_pending", int'(want.is_pending), int'(out_tdata[14]));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result sink: random stalls, plus one long hold-off counted here on request
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned stall_left;
    out_tready = 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left   = HOLD_OFF_CYCLES;
      end
      if (stall_left != 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        if ($urandom_range(0, 2) == 0) stall_left = idle_len();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // one item; returns right after the edge that accepted it
  task automatic send_cmd(input logic [2:0] kind, input logic [1:0] setting,
                          input logic [7:0] delta);
    int unsigned gap;
    gap = idle_len();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {6'b0, delta, setting};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_ticks(input int unsigned n);
    repeat (n) send_cmd(KIND_TICK, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
  endtask

  // tidy commands carry mostly small steps; noise may be any kind at all
  task automatic send_random_cmd(input bit tidy);
    logic [2:0] kind;
    logic [7:0] delta;
    if (tidy) begin
      kind = 3'($urandom_range(1, 6));
      if ($urandom_range(0, 3) != 0) begin
        delta = 8'($urandom_range(0, 8));
        delta = delta - 8'd4;
      end else begin
        delta = 8'($urandom_range(0, 255));
      end
    end else begin
      kind  = 3'($urandom_range(0, 7));
      delta = 8'($urandom_range(0, 255));
    end
    send_cmd(kind, 2'($urandom_range(0, 3)), delta);
  endtask

  // wait out every report, then the two-stage pipe with margin
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (reports_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // setup then access phase; only called with the block idle
  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    case (idx)
      REG_SETTLE:  lim_settle  = value[15:0];
      REG_REFRESH: lim_refresh = value[19:0];
      REG_MIN_SP:  lim_min_sp  = value[6:0];
      REG_MAX_SP:  lim_max_sp  = value[6:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [15:0] settle, input logic [19:0] refresh,
                           input logic [6:0] lo, input logic [6:0] hi);
    drain();
    write_reg(REG_SETTLE, 32'(settle));
    write_reg(REG_REFRESH, 32'(refresh));
    write_reg(REG_MIN_SP, 32'(lo));
    write_reg(REG_MAX_SP, 32'(hi));
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset registers: out-of-range and changed settings, unused kind,
  // setpoint steps that hit both bounds
  task automatic test_reset_defaults();
    send_cmd(KIND_UNUSED, 2'd3, 8'hFF);
    send_cmd(KIND_POWER, 2'd2, 8'h00);
    send_cmd(KIND_POWER, 2'd3, 8'h00);
    send_cmd(KIND_POWER, 2'd1, 8'h00);
    send_cmd(KIND_MODE, 2'd3, 8'h00);
    send_cmd(KIND_MODE, 2'd0, 8'h00);
    send_cmd(KIND_FAN, 2'd3, 8'h00);
    send_cmd(KIND_SWING_V, 2'd2, 8'h00);
    send_cmd(KIND_SWING_V, 2'd1, 8'h00);
    send_cmd(KIND_SWING_H, 2'd3, 8'h00);
    send_cmd(KIND_DELTA, 2'd0, 8'h7F);
    send_cmd(KIND_DELTA, 2'd0, 8'h80);
    send_ticks(1);
  endtask

  // shortest nonzero intervals: change frame, refresh, change during refresh
  task automatic test_frame_timing();
    write_all(16'd1, 20'd1, MIN_SP_RST, MAX_SP_RST);
    send_ticks(3);
    send_cmd(KIND_FAN, 2'd1, 8'h00);
    send_ticks(2);
    send_cmd(KIND_POWER, 2'd0, 8'h00);
    send_ticks(1);
  endtask

  // zero intervals fire on the very next tick
  task automatic test_zero_intervals();
    write_all(16'd0, 20'd0, MIN_SP_RST, MAX_SP_RST);
    send_cmd(KIND_MODE, 2'd1, 8'h00);
    send_ticks(3);
  endtask

  // setpoint outside new bounds, inverted range and both extremes
  task automatic test_setpoint_bounds();
    write_all(16'd2, 20'd3, 7'd80, 7'd90);
    send_ticks(1);
    send_cmd(KIND_DELTA, 2'd0, 8'h00);
    write_all(16'd2, 20'd3, 7'd100, 7'd50);
    send_cmd(KIND_DELTA, 2'd0, 8'h01);
    send_ticks(3);
    write_all(16'd2, 20'd3, 7'd0, 7'd127);
    send_cmd(KIND_DELTA, 2'd0, 8'h80);
    send_cmd(KIND_DELTA, 2'd0, 8'h80);
    send_cmd(KIND_DELTA, 2'd0, 8'h7F);
    send_cmd(KIND_DELTA, 2'd0, 8'h7F);
    send_cmd(KIND_DELTA, 2'd0, 8'hFF);
    write_all(16'd2, 20'd3, 7'd127, 7'd127);
    send_cmd(KIND_DELTA, 2'd0, 8'h80);
    write_all(16'd2, 20'd3, 7'd0, 7'd0);
    send_cmd(KIND_DELTA, 2'd0, 8'h7F);
    send_ticks(4);
  endtask

  // phases of random settings; mostly change bursts followed by quiet ticks
  task automatic test_random_traffic(input int unsigned n_items, input int unsigned phases);
    int unsigned goal;
    int unsigned lo;
    int unsigned hi;
    repeat (phases) begin
      if ($urandom_range(0, 4) == 0) begin
        lo = $urandom_range(0, 127);
        hi = $urandom_range(0, 127);
      end else begin
        lo = $urandom_range(40, 75);
        hi = $urandom_range(lo, 100);
      end
      write_all(16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 2)
                                                : $urandom_range(1, 10)),
                20'($urandom_range(0, 20)), 7'(lo), 7'(hi));
      // some phases run without idling
      steady = ($urandom_range(0, 3) == 0);
      goal   = items_sent + n_items / phases;
      while (items_sent < goal) begin
        if ($urandom_range(0, 9) < 7) begin
          repeat ($urandom_range(1, 4)) send_random_cmd(1'b1);
          send_ticks($urandom_range(0, lim_settle + lim_refresh + 3));
        end else begin
          send_random_cmd(1'b0);
        end
      end
      steady = 1'b0;
    end
  endtask

  // receiver holds off long while items keep coming, so the input stalls
  task automatic test_input_backpressure();
    write_all(16'd3, 20'd5, MIN_SP_RST, MAX_SP_RST);
    steady       = 1'b1;
    hold_off_req = 1'b1;
    repeat (40) begin
      if ($urandom_range(0, 1) == 0) send_random_cmd(1'b1);
      else send_ticks(1);
    end
    steady = 1'b0;
  endtask

  // long settle wait and widest refresh period; the change frame needs
  // every quiet tick and no refresh follows
  task automatic test_long_settle();
    write_all(16'd100, 20'hFFFFF, 7'd0, 7'd127);
    steady = 1'b1;
    send_cmd(KIND_POWER, {1'b0, ~sh_power}, 8'h00);
    send_ticks(104);
    send_cmd(KIND_DELTA, 2'd0, 8'h01);
    send_ticks(10);
    steady = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = '0;
    cfg_psel     = 1'b0;
    cfg_penable  = 1'b0;
    cfg_pwrite   = 1'b0;
    cfg_paddr    = '0;
    cfg_pwdata   = '0;
    mismatches   = 0;
    items_sent   = 0;
    steady       = 1'b0;
    hold_off_req = 1'b0;
    // shadow starts from the reset values
    lim_settle       = SETTLE_RST;
    lim_refresh      = REFRESH_RST;
    lim_min_sp       = MIN_SP_RST;
    lim_max_sp       = MAX_SP_RST;
    sh_power         = 1'b0;
    sh_mode          = MODE_RST;
    sh_setpoint      = SETPOINT_RST;
    sh_fan           = 2'd0;
    sh_vane_v        = 1'b0;
    sh_vane_h        = 1'b0;
    sh_pending       = 1'b0;
    quiet_ticks      = '0;
    ticks_since_send = '0;
    sent_once        = 1'b0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_frame_timing();
    test_zero_intervals();
    test_setpoint_bounds();
    test_random_traffic(500, 3);
    test_input_backpressure();
    test_random_traffic(450, 3);
    test_long_settle();

    drain();
    if (mismatches == 0 && reports_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // hang guard, far above the slowest legal run
  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
